// ===== hdl/cpq_pkg.sv =====
// Shared types, field widths and codes of the coalescing parameter queue.
package cpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int DEVICES_DEF = 4;
  localparam int CHANNELS_PER_DEVICE_DEF = 4;

  localparam int CHAN_W = 4;
  localparam int TYPE_W = 8;
  localparam int VALUE_W = 32;
  localparam int DRAIN_W = 2;
  localparam int STATUS_W = 3;
  localparam int OUT_CHAN_W = 2;

  localparam int DEVCNT_W = 3;
  localparam int BLIM_W = 6;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_RESULTS = 32;
  localparam int LEFT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [DEVCNT_W-1:0] DEVCNT_RESET = DEVCNT_W'(4);
  localparam logic [BLIM_W-1:0] BLIM_RESET = BLIM_W'(30);

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIMIT = 1'b1;

  localparam logic OP_POST = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_APPENDED   = 3'd0,
    ST_MERGED     = 3'd1,
    ST_BAD_DEVICE = 3'd2,
    ST_FULL       = 3'd3,
    ST_ENTRY      = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_BUSY       = 3'd6
  } status_t;

  typedef struct packed {
    logic                      operation;
    logic [CHAN_W-1:0]         channel;
    logic [TYPE_W-1:0]         param_type;
    logic signed [VALUE_W-1:0] param_value;
    logic [DRAIN_W-1:0]        drain_device;
    logic                      dsp_busy;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic [OUT_CHAN_W-1:0]     out_channel;
    logic [TYPE_W-1:0]         out_type;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic launch;
    logic pop;
    logic append;
  } lane_ctl_t;

endpackage

// ===== hdl/cpq_if.sv =====
// Valid/ready channel interfaces for request and result transfers.
interface cpq_in_if import cpq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpq_out_if import cpq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cpq_cell.sv =====
// One queue slot: holds an entry, matches a passing probe, shifts toward the head.
module cpq_cell import cpq_pkg::*; #(
  parameter int LW = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               occupied,
  input  logic               pop,
  input  logic               wr,
  input  logic               probe_in,
  input  logic               hit_in,
  input  logic [LW-1:0]      key_chan,
  input  logic [TYPE_W-1:0]  key_type,
  input  logic [VALUE_W-1:0] key_value,
  input  logic [LW-1:0]      nb_chan,
  input  logic [TYPE_W-1:0]  nb_type,
  input  logic [VALUE_W-1:0] nb_value,
  output logic [LW-1:0]      chan,
  output logic [TYPE_W-1:0]  ptype,
  output logic [VALUE_W-1:0] value,
  output logic               probe_out,
  output logic               hit_out
);

  logic [LW-1:0]      chan_r;
  logic [TYPE_W-1:0]  type_r;
  logic [VALUE_W-1:0] value_r;
  logic               probe_r;
  logic               hit_r;
  logic               match;

  assign match = probe_in && occupied && (chan_r == key_chan) && (type_r == key_type);

  always_ff @(posedge clk) begin
    if (pop) begin
      chan_r  <= nb_chan;
      type_r  <= nb_type;
      value_r <= nb_value;
    end else if (wr) begin
      chan_r  <= key_chan;
      type_r  <= key_type;
      value_r <= key_value;
    end else if (match) begin
      value_r <= key_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      probe_r <= probe_in;
      hit_r   <= hit_in | match;
    end
  end

  assign chan      = chan_r;
  assign ptype     = type_r;
  assign value     = value_r;
  assign probe_out = probe_r;
  assign hit_out   = hit_r;

endmodule

// ===== hdl/cpq_lane.sv =====
// One device queue: a row of slots with the head at slot zero and a fill count.
module cpq_lane import cpq_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int LW = 2,
  parameter int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lane_ctl_t          ctl,
  input  logic [LW-1:0]      key_chan,
  input  logic [TYPE_W-1:0]  key_type,
  input  logic [VALUE_W-1:0] key_value,
  output logic [LW-1:0]      head_chan,
  output logic [TYPE_W-1:0]  head_type,
  output logic [VALUE_W-1:0] head_value,
  output logic [CW-1:0]      count,
  output logic               done,
  output logic               hit
);

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [LW-1:0]      c_chan  [DEPTH];
  logic [TYPE_W-1:0]  c_type  [DEPTH];
  logic [VALUE_W-1:0] c_value [DEPTH];
  logic [DEPTH-1:0]   c_probe;
  logic [DEPTH-1:0]   c_hit;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [LW-1:0]      nb_chan;
      logic [TYPE_W-1:0]  nb_type;
      logic [VALUE_W-1:0] nb_value;
      logic               p_in;
      logic               h_in;

      if (i == DEPTH - 1) begin : g_tail
        assign nb_chan  = '0;
        assign nb_type  = '0;
        assign nb_value = '0;
      end else begin : g_mid
        assign nb_chan  = c_chan[i+1];
        assign nb_type  = c_type[i+1];
        assign nb_value = c_value[i+1];
      end

      if (i == 0) begin : g_head
        assign p_in = ctl.launch;
        assign h_in = 1'b0;
      end else begin : g_body
        assign p_in = c_probe[i-1];
        assign h_in = c_hit[i-1];
      end

      cpq_cell #(.LW(LW)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .occupied  (CW'(i) < count_r),
        .pop       (ctl.pop),
        .wr        (ctl.append && (count_r == CW'(i))),
        .probe_in  (p_in),
        .hit_in    (h_in),
        .key_chan  (key_chan),
        .key_type  (key_type),
        .key_value (key_value),
        .nb_chan   (nb_chan),
        .nb_type   (nb_type),
        .nb_value  (nb_value),
        .chan      (c_chan[i]),
        .ptype     (c_type[i]),
        .value     (c_value[i]),
        .probe_out (c_probe[i]),
        .hit_out   (c_hit[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.append) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_chan  = c_chan[0];
  assign head_type  = c_type[0];
  assign head_value = c_value[0];
  assign count      = count_r;
  assign done       = c_probe[DEPTH-1];
  assign hit        = c_hit[DEPTH-1];

endmodule

// ===== hdl/coalescing_param_queue.sv =====
// Top level of the write-coalescing parameter-update queue.
// One ordered queue per device, each a row of QUEUE_DEPTH slots with the head at
// slot zero. A post sends a probe down its device's row, one slot a cycle; a
// slot holding the same local channel and type takes the new value on the spot,
// otherwise the entry is appended at the tail unless the row is full. The next
// request is accepted only once the probe has walked the whole row. A drain pops
// one entry a cycle from the head, shifting the row, while the result side keeps
// up, and gives at most the batch limit (clamped to 1..32) of results. One
// request is in work at a time; a finished result waits in the output register
// while the next request is accepted. The slots have no reset; the fill counts
// reset to zero, so no clearing pass is needed.
module coalescing_param_queue import cpq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int DEVICES = DEVICES_DEF,
  parameter int CHANNELS_PER_DEVICE = CHANNELS_PER_DEVICE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cpq_in_if.sink                in_ch,
  cpq_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LW = (CHANNELS_PER_DEVICE > 1) ? $clog2(CHANNELS_PER_DEVICE) : 1;
  localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = (CW > BLIM_W) ? CW : BLIM_W;
  localparam logic [4:0] DEV_LIM = 5'(DEVICES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PROBE = 4'b0010,
    S_REPLY = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [DW-1:0]       dev_r, dev_nxt;
  logic [LW-1:0]       key_chan_r, key_chan_nxt;
  logic [TYPE_W-1:0]   key_type_r, key_type_nxt;
  logic [VALUE_W-1:0]  key_value_r, key_value_nxt;
  status_t             status_r, status_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  logic                launch_r, launch_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [DEVCNT_W-1:0] devcnt_r;
  logic [BLIM_W-1:0]   blim_r;

  logic [LW-1:0]       l_chan  [DEVICES];
  logic [TYPE_W-1:0]   l_type  [DEVICES];
  logic [VALUE_W-1:0]  l_value [DEVICES];
  logic [CW-1:0]       l_count [DEVICES];
  logic [DEVICES-1:0]  l_done;
  logic [DEVICES-1:0]  l_hit;

  logic                in_acc;
  logic                out_free;
  logic                launch_now, pop_now, app_now;
  logic [CHAN_W-1:0]   post_dev;
  logic [CHAN_W-1:0]   post_loc;
  logic [4:0]          dev_limit;
  logic                drain_bad;
  logic [DW-1:0]       sel_dev;
  logic [CW-1:0]       sel_cnt;
  logic [NW-1:0]       cnt_w, lim_w;
  logic [LEFT_W-1:0]   n_pop;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Split the global channel into device and local channel.
  always_comb begin
    post_dev = '0;
    for (int d = 1; d < 16; d++) begin
      if (int'(in_ch.data.channel) >= d * CHANNELS_PER_DEVICE) begin
        post_dev = CHAN_W'(d);
      end
    end
    post_loc = in_ch.data.channel - CHAN_W'(int'(post_dev) * CHANNELS_PER_DEVICE);
  end

  assign dev_limit = ({2'b00, devcnt_r} < DEV_LIM) ? {2'b00, devcnt_r} : DEV_LIM;
  assign drain_bad = {3'b000, in_ch.data.drain_device} >= DEV_LIM;

  assign sel_dev = (state_r != S_IDLE) ? dev_r :
                   (in_ch.data.operation == OP_DRAIN) ? DW'(in_ch.data.drain_device) :
                   DW'(post_dev);
  assign sel_cnt = l_count[sel_dev];

  always_comb begin
    cnt_w = NW'(sel_cnt);
    if (blim_r == '0) begin
      lim_w = NW'(1);
    end else if (int'(blim_r) > MAX_RESULTS) begin
      lim_w = NW'(MAX_RESULTS);
    end else begin
      lim_w = NW'(blim_r);
    end
    n_pop = LEFT_W'((cnt_w < lim_w) ? cnt_w : lim_w);
  end

  always_comb begin
    state_nxt     = state_r;
    dev_nxt       = dev_r;
    key_chan_nxt  = key_chan_r;
    key_type_nxt  = key_type_r;
    key_value_nxt = key_value_r;
    status_nxt    = status_r;
    left_nxt      = left_r;
    launch_nxt    = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    launch_now    = 1'b0;
    pop_now       = 1'b0;
    app_now       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.data.operation == OP_POST) begin
            if ({1'b0, post_dev} >= dev_limit) begin
              status_nxt = ST_BAD_DEVICE;
              state_nxt  = S_REPLY;
            end else begin
              dev_nxt       = DW'(post_dev);
              key_chan_nxt  = LW'(post_loc);
              key_type_nxt  = in_ch.data.param_type;
              key_value_nxt = in_ch.data.param_value;
              launch_nxt    = 1'b1;
              state_nxt     = S_PROBE;
            end
          end else if (drain_bad) begin
            status_nxt = ST_BAD_DEVICE;
            state_nxt  = S_REPLY;
          end else if (in_ch.data.dsp_busy) begin
            status_nxt = ST_BUSY;
            state_nxt  = S_REPLY;
          end else if (sel_cnt == '0) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_REPLY;
          end else begin
            dev_nxt   = DW'(in_ch.data.drain_device);
            left_nxt  = n_pop;
            state_nxt = S_DRAIN;
          end
        end
      end
      S_PROBE: begin
        launch_now = launch_r;
        if (l_done[dev_r]) begin
          state_nxt = S_REPLY;
          if (l_hit[dev_r]) begin
            status_nxt = ST_MERGED;
          end else if (sel_cnt == CW'(QUEUE_DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_APPENDED;
            app_now    = 1'b1;
          end
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.out_channel = '0;
          out_data_nxt.out_type    = '0;
          out_data_nxt.out_value   = '0;
          out_data_nxt.last        = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          pop_now                  = 1'b1;
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ST_ENTRY;
          out_data_nxt.out_channel = OUT_CHAN_W'(l_chan[dev_r]);
          out_data_nxt.out_type    = l_type[dev_r];
          out_data_nxt.out_value   = l_value[dev_r];
          out_data_nxt.last        = (left_r == LEFT_W'(1));
          left_nxt                 = left_r - LEFT_W'(1);
          if (left_r == LEFT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      devcnt_r    <= DEVCNT_RESET;
      blim_r      <= BLIM_RESET;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
      left_r      <= left_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DEVICE_COUNT: devcnt_r <= cfg_data[DEVCNT_W-1:0];
          REG_BATCH_LIMIT:  blim_r   <= cfg_data[BLIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    dev_r       <= dev_nxt;
    key_chan_r  <= key_chan_nxt;
    key_type_r  <= key_type_nxt;
    key_value_r <= key_value_nxt;
    status_r    <= status_nxt;
    out_data_r  <= out_data_nxt;
  end

  genvar g;
  generate
    for (g = 0; g < DEVICES; g++) begin : g_lane
      lane_ctl_t ctl;
      assign ctl.launch = launch_now && (dev_r == DW'(g));
      assign ctl.pop    = pop_now && (dev_r == DW'(g));
      assign ctl.append = app_now && (dev_r == DW'(g));

      cpq_lane #(.DEPTH(QUEUE_DEPTH), .LW(LW), .CW(CW)) u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .key_chan   (key_chan_r),
        .key_type   (key_type_r),
        .key_value  (key_value_r),
        .head_chan  (l_chan[g]),
        .head_type  (l_type[g]),
        .head_value (l_value[g]),
        .count      (l_count[g]),
        .done       (l_done[g]),
        .hit        (l_hit[g])
      );
    end
  endgenerate

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_drain_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (left_r != '0))
    else $error("drain state with no entries left");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PROBE) || (state_r == S_DRAIN)) |-> (sel_cnt <= CW'(QUEUE_DEPTH)))
    else $error("queue count above depth");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_ENTRY)) |-> out_data_r.last)
    else $error("non-entry result without last");

  a_post_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.data.operation == OP_POST) && ({1'b0, post_dev} < dev_limit))
      |=> (state_r == S_PROBE) && launch_r)
    else $error("accepted post did not launch a probe");

endmodule

// ===== sim/tb_coalescing_param_queue.sv =====
// Self-checking testbench for the coalescing parameter queue: random traffic against a predictor.
module tb_coalescing_param_queue import cpq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int DEVS = DEVICES_DEF;
  localparam int CHANS = CHANNELS_PER_DEVICE_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [OUT_CHAN_W-1:0] lchan;
    logic [TYPE_W-1:0]     ptype;
    logic [VALUE_W-1:0]    pval;
  } queued_param_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  req_valid = 1'b0;
  in_item_t              req_data = '0;
  logic                  rsp_ready = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cpq_in_if  req_if ();
  cpq_out_if rsp_if ();

  assign req_if.valid = req_valid;
  assign req_if.data  = req_data;
  assign rsp_if.ready = rsp_ready;

  coalescing_param_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (rsp_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // predictor state
  queued_param_t         param_slots [DEVS][DEPTH];
  int unsigned           queue_start [DEVS] = '{default: 0};
  int unsigned           queue_fill [DEVS] = '{default: 0};
  logic [DEVCNT_W-1:0]   devices_present = DEVCNT_RESET;
  logic [BLIM_W-1:0]     batch_cap = BLIM_RESET;

  in_item_t    pending_requests [$];
  out_item_t   expected_responses [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          steady_phase = 1'b0;

  function automatic void add_request(in_item_t it);
    pending_requests = {pending_requests, it};
  endfunction

  function automatic bit take_gap();
    return !steady_phase && ($urandom_range(99) < 30);
  endfunction

  function automatic void expect_response(status_t st, logic [OUT_CHAN_W-1:0] ch,
                                          logic [TYPE_W-1:0] ty, logic [VALUE_W-1:0] v,
                                          logic lst);
    out_item_t r;
    r.status = st;
    r.out_channel = ch;
    r.out_type = ty;
    r.out_value = v;
    r.last = lst;
    expected_responses = {expected_responses, r};
  endfunction

  function automatic void predict_request(in_item_t req);
    int unsigned dev, lim, n, pos, i;
    logic [OUT_CHAN_W-1:0] lchan;
    queued_param_t q;
    if (req.operation == OP_POST) begin
      dev = req.channel / CHANS;
      lchan = OUT_CHAN_W'(req.channel % CHANS);
      lim = (devices_present < DEVS) ? devices_present : DEVS;
      if (dev >= lim) begin
        expect_response(ST_BAD_DEVICE, '0, '0, '0, 1'b1);
        return;
      end
      for (i = 0; i < queue_fill[dev]; i++) begin
        pos = (queue_start[dev] + i) % DEPTH;
        if (param_slots[dev][pos].lchan == lchan &&
            param_slots[dev][pos].ptype == req.param_type) begin
          param_slots[dev][pos].pval = req.param_value;
          expect_response(ST_MERGED, '0, '0, '0, 1'b1);
          return;
        end
      end
      if (queue_fill[dev] >= DEPTH) begin
        expect_response(ST_FULL, '0, '0, '0, 1'b1);
        return;
      end
      pos = (queue_start[dev] + queue_fill[dev]) % DEPTH;
      param_slots[dev][pos] = '{lchan: lchan, ptype: req.param_type, pval: req.param_value};
      queue_fill[dev]++;
      expect_response(ST_APPENDED, '0, '0, '0, 1'b1);
    end else begin
      dev = req.drain_device;
      if (req.dsp_busy) begin
        expect_response(ST_BUSY, '0, '0, '0, 1'b1);
        return;
      end
      if (queue_fill[dev] == 0) begin
        expect_response(ST_EMPTY, '0, '0, '0, 1'b1);
        return;
      end
      lim = batch_cap;
      if (lim == 0) lim = 1;
      if (lim > MAX_RESULTS) lim = MAX_RESULTS;
      n = (queue_fill[dev] < lim) ? queue_fill[dev] : lim;
      for (i = 0; i < n; i++) begin
        q = param_slots[dev][queue_start[dev]];
        expect_response(ST_ENTRY, q.lchan, q.ptype, q.pval, i + 1 == n);
        queue_start[dev] = (queue_start[dev] + 1) % DEPTH;
        queue_fill[dev]--;
      end
    end
  endfunction

  function automatic void check_response(out_item_t got);
    out_item_t want;
    if (expected_responses.size() == 0) begin
      $error("unexpected result transfer: status %0d", got.status);
      error_count++;
      return;
    end
    want = expected_responses[0];
    expected_responses.delete(0);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      error_count++;
    end
    if (got.out_channel !== want.out_channel) begin
      $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
      error_count++;
    end
    if (got.out_type !== want.out_type) begin
      $error("out_type: expected %0d, got %0d", want.out_type, got.out_type);
      error_count++;
    end
    if (got.out_value !== want.out_value) begin
      $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
      error_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      error_count++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_if.ready) predict_request(req_data);
      if (!req_valid || req_if.ready) begin
        if (pending_requests.size() != 0 && !take_gap()) begin
          req_data <= pending_requests[0];
          pending_requests.delete(0);
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_ready && rsp_if.valid) check_response(rsp_if.data);
      rsp_ready <= !take_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("coalescing_param_queue verification failed");
      $finish;
    end
  end

  function automatic in_item_t make_post(logic [CHAN_W-1:0] ch, logic [TYPE_W-1:0] ty,
                                         logic [VALUE_W-1:0] v);
    in_item_t it;
    it.operation = OP_POST;
    it.channel = ch;
    it.param_type = ty;
    it.param_value = v;
    it.drain_device = DRAIN_W'($urandom);
    it.dsp_busy = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_drain(logic [DRAIN_W-1:0] dev, logic busy);
    in_item_t it;
    it.operation = OP_DRAIN;
    it.channel = CHAN_W'($urandom);
    it.param_type = TYPE_W'($urandom);
    it.param_value = $urandom;
    it.drain_device = dev;
    it.dsp_busy = busy;
    return it;
  endfunction

  // fill one device past capacity, then drain it
  task automatic add_fill_burst(logic [DRAIN_W-1:0] dev);
    logic [TYPE_W-1:0] base;
    int k;
    base = TYPE_W'($urandom);
    for (k = 0; k < DEPTH + 2; k++)
      add_request(make_post({dev, 2'(k % 4)}, base + TYPE_W'(k / 4), $urandom));
    add_request(make_drain(dev, 1'b0));
  endtask

  task automatic add_traffic(int unsigned count);
    int unsigned made, pick;
    logic [TYPE_W-1:0] ty;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        add_fill_burst(DRAIN_W'($urandom));
        made += DEPTH + 3;
      end else begin
        if (pick < 58) begin
          ty = $urandom_range(1) ? TYPE_W'($urandom_range(3)) : TYPE_W'($urandom);
          add_request(make_post(CHAN_W'($urandom), ty, $urandom));
        end else if (pick < 85) begin
          add_request(make_drain(DRAIN_W'($urandom), 1'b0));
        end else begin
          add_request(make_drain(DRAIN_W'($urandom), 1'b1));
        end
        made++;
      end
    end
  endtask

  task automatic settle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0);
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_DEVICE_COUNT) devices_present = val[DEVCNT_W-1:0];
    else batch_cap = val[BLIM_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    add_request(make_drain(2'd0, 1'b0));
    add_request(make_drain(2'd1, 1'b1));
    add_request(make_post(4'd0, 8'd0, 32'h8000_0000));
    add_request(make_post(4'd0, 8'd0, 32'h7fff_ffff));
    add_request(make_post(4'd1, 8'd0, 32'd5));
    add_request(make_post(4'd0, 8'd255, 32'hffff_ffff));
    add_request(make_post(4'd15, 8'd255, 32'hffff_ffff));
    add_request(make_post(4'd12, 8'd0, 32'd0));
    add_request(make_post(4'd15, 8'd255, 32'd0));
    add_request(make_drain(2'd0, 1'b1));
    add_request(make_drain(2'd0, 1'b0));
    add_request(make_drain(2'd0, 1'b0));
    add_request(make_drain(2'd3, 1'b0));
    add_request(make_post(4'd7, 8'haa, 32'h5555_5555));
    add_request(make_post(4'd11, 8'h55, 32'haaaa_aaaa));
    add_request(make_drain(2'd1, 1'b0));
    add_request(make_drain(2'd2, 1'b0));
    add_traffic(70);
    settle();

    write_setting(REG_DEVICE_COUNT, 6'd2);
    write_setting(REG_BATCH_LIMIT, 6'd1);
    add_request(make_post(4'd8, 8'd1, $urandom));
    add_request(make_post(4'd15, 8'd2, $urandom));
    add_request(make_post(4'd4, 8'd3, $urandom));
    add_request(make_post(4'd5, 8'd3, $urandom));
    add_request(make_drain(2'd1, 1'b0));
    add_request(make_drain(2'd1, 1'b0));
    add_traffic(60);
    settle();

    write_setting(REG_DEVICE_COUNT, 6'd0);
    write_setting(REG_BATCH_LIMIT, 6'd0);
    add_request(make_post(4'd0, 8'd0, $urandom));
    add_request(make_drain(2'd3, 1'b0));
    add_traffic(30);
    settle();

    write_setting(REG_DEVICE_COUNT, 6'd7);
    write_setting(REG_BATCH_LIMIT, 6'd63);
    add_fill_burst(2'd2);
    add_traffic(50);
    settle();

    write_setting(REG_DEVICE_COUNT, 6'd5);
    write_setting(REG_BATCH_LIMIT, 6'd32);
    add_traffic(50);
    settle();

    steady_phase = 1'b1;
    write_setting(REG_DEVICE_COUNT, 6'd3);
    write_setting(REG_BATCH_LIMIT, 6'd33);
    add_traffic(50);
    settle();
    steady_phase = 1'b0;

    write_setting(REG_DEVICE_COUNT, 6'd4);
    write_setting(REG_BATCH_LIMIT, 6'($urandom_range(2, 29)));
    add_traffic(40);
    settle();

    repeat (DEPTH + 8) @(posedge clk);
    if (error_count == 0 && expected_responses.size() == 0) begin
      $display("coalescing_param_queue verification clean");
    end else begin
      $display("coalescing_param_queue verification failed");
    end
    $finish;
  end

endmodule

// ===== coalescing_param_queue.f =====
hdl/cpq_pkg.sv
hdl/cpq_if.sv
hdl/cpq_cell.sv
hdl/cpq_lane.sv
hdl/coalescing_param_queue.sv
sim/tb_coalescing_param_queue.sv
